/* design/totp_pkg.sv */
// Shared types, constants and helper functions for the TOTP generator and verifier.
// Depends on nothing; every other file in the design uses it by scoped names.
package totp_pkg;

  // Limits of the block.
  localparam int MaxKeyBytes = 24;
  localparam int MaxWindow   = 15;
  localparam int KeyLim      = (MaxKeyBytes > 64) ? 64 : MaxKeyBytes;

  // Widths.
  localparam int CfgIdxW = 3;
  localparam int StepW   = $clog2(2 * MaxWindow + 2);
  localparam int CodeW   = 30;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegKey0     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey1     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey2     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKeyLen   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDigits   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegWindow   = 3'd5;

  // SHA-1 blocks of one HMAC evaluation, in order.
  localparam logic [1:0] BlkInnerKey = 2'd0;
  localparam logic [1:0] BlkInnerMsg = 2'd1;
  localparam logic [1:0] BlkOuterKey = 2'd2;
  localparam logic [1:0] BlkOuterMsg = 2'd3;

  localparam logic [6:0] LastRound   = 7'd79;
  localparam logic [6:0] LastModStep = 7'd30;

  // SHA-1 initial hash value.
  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hC3D2E1F0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             capture;
    logic             load;
    logic             round;
    logic             feed;
    logic             trunc;
    logic             mod_step;
    logic             check;
    logic [1:0]       blk;
    logic [6:0]       rnd;
    logic [StepW-1:0] step;
  } totp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic last_step;
  } totp_status_t;

  // Ten to the given power, saturated at nine digits.
  function automatic logic [CodeW-1:0] pow10(input logic [3:0] digits);
    logic [CodeW-1:0] r;
    case (digits)
      4'd0:    r = 30'd1;
      4'd1:    r = 30'd10;
      4'd2:    r = 30'd100;
      4'd3:    r = 30'd1000;
      4'd4:    r = 30'd10000;
      4'd5:    r = 30'd100000;
      4'd6:    r = 30'd1000000;
      4'd7:    r = 30'd10000000;
      4'd8:    r = 30'd100000000;
      default: r = 30'd1000000000;
    endcase
    return r;
  endfunction

endpackage

/* design/totp_datapath.sv */
// Datapath of the TOTP block: configuration registers, SHA-1 round unit with its
// message schedule, HMAC chaining, dynamic truncation and bit-serial modulo reduction.
// Depends on totp_pkg.
module totp_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [totp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [63:0]                   cfg_wdata_i,
  input  logic [63:0]                   time_counter_i,
  input  logic [29:0]                   candidate_password_i,
  input  totp_pkg::totp_cmd_t           cmd_i,
  output totp_pkg::totp_status_t        status_o,
  output logic [29:0]                   otp_code_o,
  output logic                          matched_o
);

  logic [63:0]  key0_q, key1_q, key2_q;
  logic [4:0]   key_len_q;
  logic [3:0]   digits_q;
  logic [3:0]   window_q;

  logic [63:0]  base_q;
  logic [29:0]  cand_q;
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [31:0]  h_q [5];
  logic [159:0] inner_q;
  logic [31:0]  w_q [16];
  logic [30:0]  rem_q;
  logic [30:0]  sv_q;
  logic [29:0]  code_q;
  logic         hit_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q    <= '0;
      key1_q    <= '0;
      key2_q    <= '0;
      key_len_q <= 5'd20;
      digits_q  <= 4'd6;
      window_q  <= 4'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        totp_pkg::RegKey0:   key0_q    <= cfg_wdata_i;
        totp_pkg::RegKey1:   key1_q    <= cfg_wdata_i;
        totp_pkg::RegKey2:   key2_q    <= cfg_wdata_i;
        totp_pkg::RegKeyLen: key_len_q <= cfg_wdata_i[4:0];
        totp_pkg::RegDigits: digits_q  <= cfg_wdata_i[3:0];
        totp_pkg::RegWindow: window_q  <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Key padded to one block, bytes past the length in use reading as zero.
  logic [6:0]   eff_len;
  logic [191:0] key_regs;
  logic [511:0] key_blk;
  always_comb begin
    eff_len  = ({2'b00, key_len_q} > 7'(totp_pkg::KeyLim)) ? 7'(totp_pkg::KeyLim)
                                                            : {2'b00, key_len_q};
    key_regs = {key0_q, key1_q, key2_q};
    key_blk  = '0;
    for (int i = 0; i < 24; i++) begin
      if (7'(i) < eff_len) begin
        key_blk[511 - 8*i -: 8] = key_regs[191 - 8*i -: 8];
      end
    end
  end

  // Counter for the current code: the base, then base-k and base+k in turn.
  localparam int StepKW = totp_pkg::StepW;
  logic [StepKW-1:0] k_off;
  logic [63:0] cur_ctr;
  always_comb begin
    k_off   = StepKW'((({1'b0, cmd_i.step}) + 1'b1) >> 1);
    cur_ctr = cmd_i.step[0] ? base_q - 64'(k_off) : base_q + 64'(k_off);
  end

  // Message block selected for loading.
  logic [511:0] blk_words;
  always_comb begin
    case (cmd_i.blk)
      totp_pkg::BlkInnerKey: blk_words = key_blk ^ {64{8'h36}};
      totp_pkg::BlkInnerMsg: blk_words = {cur_ctr, 32'h80000000, 384'd0, 32'd576};
      totp_pkg::BlkOuterKey: blk_words = key_blk ^ {64{8'h5C}};
      default:               blk_words = {inner_q, 32'h80000000, 288'd0, 32'd672};
    endcase
  end

  // One SHA-1 round.
  logic [31:0] f_val, k_val, t_val, w_new;
  always_comb begin
    if (cmd_i.rnd < 7'd20) begin
      f_val = (b_q & c_q) | (~b_q & d_q);
      k_val = 32'h5A827999;
    end else if (cmd_i.rnd < 7'd40) begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = 32'h6ED9EBA1;
    end else if (cmd_i.rnd < 7'd60) begin
      f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_val = 32'h8F1BBCDC;
    end else begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = 32'hCA62C1D6;
    end
    t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_q[0];
    w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  // Dynamic truncation of the final digest.
  logic [159:0] digest;
  logic [159:0] dig_sh;
  logic [3:0]   trunc_off;
  always_comb begin
    digest    = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
    trunc_off = h_q[4][3:0];
    dig_sh    = digest >> {(5'd16 - {1'b0, trunc_off}), 3'b000};
  end

  // One restoring step of the reduction modulo ten to the digit count.
  logic [29:0] modulus;
  logic [31:0] rem_shift;
  logic [30:0] rem_next;
  logic        match;
  always_comb begin
    modulus   = totp_pkg::pow10((digits_q > 4'd9) ? 4'd9 : digits_q);
    rem_shift = {rem_q, sv_q[30]};
    rem_next  = (rem_shift >= {2'b00, modulus}) ? 31'(rem_shift - {2'b00, modulus})
                                                : rem_shift[30:0];
    match     = (rem_q[29:0] == cand_q);
  end

  // Hash state, schedule, reduction and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      base_q <= time_counter_i;
      cand_q <= candidate_password_i;
    end
    if (cmd_i.load) begin
      for (int j = 0; j < 16; j++) begin
        w_q[j] <= blk_words[511 - 32*j -: 32];
      end
      if (cmd_i.blk == totp_pkg::BlkInnerKey || cmd_i.blk == totp_pkg::BlkOuterKey) begin
        h_q[0] <= totp_pkg::Iv0; h_q[1] <= totp_pkg::Iv1; h_q[2] <= totp_pkg::Iv2;
        h_q[3] <= totp_pkg::Iv3; h_q[4] <= totp_pkg::Iv4;
        a_q <= totp_pkg::Iv0; b_q <= totp_pkg::Iv1; c_q <= totp_pkg::Iv2;
        d_q <= totp_pkg::Iv3; e_q <= totp_pkg::Iv4;
      end else begin
        a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
      end
    end
    if (cmd_i.round) begin
      a_q <= t_val;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
      for (int j = 0; j < 15; j++) begin
        w_q[j] <= w_q[j+1];
      end
      w_q[15] <= w_new;
    end
    if (cmd_i.feed) begin
      h_q[0] <= h_q[0] + a_q;
      h_q[1] <= h_q[1] + b_q;
      h_q[2] <= h_q[2] + c_q;
      h_q[3] <= h_q[3] + d_q;
      h_q[4] <= h_q[4] + e_q;
      if (cmd_i.blk == totp_pkg::BlkInnerMsg) begin
        inner_q <= {h_q[0] + a_q, h_q[1] + b_q, h_q[2] + c_q, h_q[3] + d_q, h_q[4] + e_q};
      end
    end
    if (cmd_i.trunc) begin
      rem_q <= '0;
      sv_q  <= dig_sh[30:0];
    end
    if (cmd_i.mod_step) begin
      rem_q <= rem_next;
      sv_q  <= {sv_q[29:0], 1'b0};
    end
  end

  // Result flag and code, cleared of stale values by the first check of each item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
      hit_q  <= 1'b0;
    end else if (cmd_i.check) begin
      if (cmd_i.step == '0) begin
        code_q <= rem_q[29:0];
        hit_q  <= match;
      end else begin
        hit_q  <= hit_q | match;
      end
    end
  end

  // Status and results.
  logic [3:0] win_eff;
  always_comb begin
    win_eff            = (32'(window_q) > totp_pkg::MaxWindow) ? 4'(totp_pkg::MaxWindow)
                                                               : window_q;
    status_o.hit       = hit_q;
    status_o.last_step = ({1'b0, cmd_i.step} >= (StepKW + 1)'({win_eff, 1'b0}));
  end

  assign otp_code_o = code_q;
  assign matched_o  = hit_q;

endmodule

/* design/totp_ctrl.sv */
// Controller of the TOTP block: sequences the four SHA-1 blocks of each code,
// the truncation and reduction, and the walk over the window of counters.
// Depends on totp_pkg.
module totp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  totp_pkg::totp_status_t status_i,
  output totp_pkg::totp_cmd_t    cmd_o,
  output logic                   busy_o,
  output logic                   done_o
);

  typedef enum logic [2:0] {
    StIdle, StLoad, StRound, StFeed, StTrunc, StMod, StCheck, StNext
  } state_e;

  state_e                     state_q;
  logic [1:0]                 blk_q;
  logic [6:0]                 cnt_q;
  logic [totp_pkg::StepW-1:0] step_q;
  logic                       busy_q;
  logic                       done_q;

  // State, counters and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      blk_q   <= totp_pkg::BlkInnerKey;
      cnt_q   <= '0;
      step_q  <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= StLoad;
            blk_q   <= totp_pkg::BlkInnerKey;
            step_q  <= '0;
            busy_q  <= 1'b1;
          end
        end
        StLoad: begin
          cnt_q   <= '0;
          state_q <= StRound;
        end
        StRound: begin
          if (cnt_q == totp_pkg::LastRound) begin
            state_q <= StFeed;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        StFeed: begin
          if (blk_q == totp_pkg::BlkOuterMsg) begin
            state_q <= StTrunc;
          end else begin
            blk_q   <= blk_q + 2'd1;
            state_q <= StLoad;
          end
        end
        StTrunc: begin
          cnt_q   <= '0;
          state_q <= StMod;
        end
        StMod: begin
          if (cnt_q == totp_pkg::LastModStep) begin
            state_q <= StCheck;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        StCheck: begin
          state_q <= StNext;
        end
        StNext: begin
          if (status_i.hit || status_i.last_step) begin
            done_q  <= 1'b1;
            busy_q  <= 1'b0;
            state_q <= StIdle;
          end else begin
            step_q  <= step_q + 1'b1;
            blk_q   <= totp_pkg::BlkInnerKey;
            state_q <= StLoad;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Commands decoded from the state.
  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == StIdle) && start_i;
    cmd_o.load     = (state_q == StLoad);
    cmd_o.round    = (state_q == StRound);
    cmd_o.feed     = (state_q == StFeed);
    cmd_o.trunc    = (state_q == StTrunc);
    cmd_o.mod_step = (state_q == StMod);
    cmd_o.check    = (state_q == StCheck);
    cmd_o.blk      = blk_q;
    cmd_o.rnd      = cnt_q;
    cmd_o.step     = step_q;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

/* design/totp_generate_and_verify.sv */
// TOTP (HMAC-SHA1) generator and verifier. Each code takes four SHA-1 compressions
// on one shared round unit plus truncation and reduction. An item computes up to
// 1 + 2 * window codes, fewer when a match ends the walk early; one item is in work at a time.
// Reset is asynchronous and restores the configuration defaults; results are
// strobed for one cycle on done_o and the receiver cannot stall them.
module totp_generate_and_verify (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [totp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [63:0]                   cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [63:0]                   time_counter_i,
  input  logic [29:0]                   candidate_password_i,
  output logic                          done_o,
  output logic [29:0]                   otp_code_o,
  output logic                          matched_o
);

  totp_pkg::totp_cmd_t    cmd;
  totp_pkg::totp_status_t status;

  // Sequencer.
  totp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  // Hashing and checking datapath.
  totp_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .time_counter_i       (time_counter_i),
    .candidate_password_i (candidate_password_i),
    .cmd_i                (cmd),
    .status_o             (status),
    .otp_code_o           (otp_code_o),
    .matched_o            (matched_o)
  );

endmodule
